>>> src/gyro_fifo_frame_conditioner_unit_defines.svh
// ----------------------------------------------------------------------------
// gyro fifo frame conditioner: assertion macros
// shared checks on the clock clk with synchronous active-low reset rst_n
// ----------------------------------------------------------------------------
`ifndef GYRO_FIFO_FRAME_CONDITIONER_UNIT_DEFINES_SVH
`define GYRO_FIFO_FRAME_CONDITIONER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define GFFC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define GFFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/gffc_pkg.sv
// ----------------------------------------------------------------------------
// gffc_pkg
// types, constants and register codes of the gyro frame conditioner
// ----------------------------------------------------------------------------
`default_nettype none

package gffc_pkg;

  // frame layout
  localparam int FRAME_BYTES = 6;
  localparam int STORE_BYTES = FRAME_BYTES - 1;
  localparam logic [2:0] LAST_POS = 3'(FRAME_BYTES - 1);

  // queue depths
  localparam int MQ_DEPTH = 2;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // config port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // register indexes
  typedef enum logic [2:0] {
    REG_BIAS_X     = 3'd0,
    REG_BIAS_Y     = 3'd1,
    REG_BIAS_Z     = 3'd2,
    REG_RATE_SCALE = 3'd3,
    REG_AXIS_MAP   = 3'd4,
    REG_SIGN_MASK  = 3'd5
  } reg_idx_t;

  // register reset values
  localparam logic [19:0] RATE_SCALE_RST = 20'd2235;
  localparam logic [5:0]  AXIS_MAP_RST   = 6'd36;

  // axis source selector codes (anything else picks z)
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;

  // rate limits, signed q8.16
  localparam logic signed [30:0] RATE_MAX = 31'sd8388607;
  localparam logic signed [30:0] RATE_MIN = -31'sd8388608;

  typedef logic signed [15:0] count_t;
  typedef logic signed [23:0] rate_t;

  typedef struct packed {
    count_t raw_x;
    count_t raw_y;
    count_t raw_z;
  } frame_t;

  typedef struct packed {
    rate_t  roll_rate;
    rate_t  pitch_rate;
    rate_t  yaw_rate;
    count_t raw_x;
    count_t raw_y;
    count_t raw_z;
    logic   clipped;
  } result_t;

  typedef struct packed {
    logic signed [19:0] bias_x;
    logic signed [19:0] bias_y;
    logic signed [19:0] bias_z;
    logic [19:0]        rate_scale;
    logic [5:0]         axis_map;
    logic [2:0]         sign_mask;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/gffc_regs.sv
// ----------------------------------------------------------------------------
// gffc_regs
// apb register file holding bias, scale, axis map and sign mask
// ----------------------------------------------------------------------------
`default_nettype none

module gffc_regs import gffc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_BIAS_X:     cfg_nxt.bias_x     = pwdata[19:0];
        REG_BIAS_Y:     cfg_nxt.bias_y     = pwdata[19:0];
        REG_BIAS_Z:     cfg_nxt.bias_z     = pwdata[19:0];
        REG_RATE_SCALE: cfg_nxt.rate_scale = pwdata[19:0];
        REG_AXIS_MAP:   cfg_nxt.axis_map   = pwdata[5:0];
        REG_SIGN_MASK:  cfg_nxt.sign_mask  = pwdata[2:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias_x     <= '0;
      cfg_r.bias_y     <= '0;
      cfg_r.bias_z     <= '0;
      cfg_r.rate_scale <= RATE_SCALE_RST;
      cfg_r.axis_map   <= AXIS_MAP_RST;
      cfg_r.sign_mask  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_BIAS_X:     prdata = {{(APB_DW-20){1'b0}}, cfg_r.bias_x};
      REG_BIAS_Y:     prdata = {{(APB_DW-20){1'b0}}, cfg_r.bias_y};
      REG_BIAS_Z:     prdata = {{(APB_DW-20){1'b0}}, cfg_r.bias_z};
      REG_RATE_SCALE: prdata = {{(APB_DW-20){1'b0}}, cfg_r.rate_scale};
      REG_AXIS_MAP:   prdata = {{(APB_DW-6){1'b0}}, cfg_r.axis_map};
      REG_SIGN_MASK:  prdata = {{(APB_DW-3){1'b0}}, cfg_r.sign_mask};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/gffc_front.sv
// ----------------------------------------------------------------------------
// gffc_front
// byte assembler: collects big-endian frames and hands raw counts onward
// ----------------------------------------------------------------------------
`default_nettype none

`include "gyro_fifo_frame_conditioner_unit_defines.svh"

module gffc_front import gffc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_frame_start,
  input  wire logic       q_full,
  output logic            q_push,
  output frame_t          q_frame
);

  logic [2:0] pos_r, pos_nxt;
  logic [2:0] pos_cur;
  logic [7:0] fb_r [STORE_BYTES];
  logic       accept;
  logic       last;

  assign full    = q_full;
  assign accept  = push && !q_full;
  // a frame start realigns to the first byte
  assign pos_cur = in_frame_start ? 3'd0 : pos_r;
  assign last    = (pos_cur >= LAST_POS);
  assign q_push  = accept && last;

  // frame assembly from stored bytes and the closing byte
  assign q_frame.raw_x = {fb_r[0], fb_r[1]};
  assign q_frame.raw_y = {fb_r[2], fb_r[3]};
  assign q_frame.raw_z = {fb_r[4], in_data_byte};

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = last ? 3'd0 : pos_cur + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // byte store, no reset needed
  always_ff @(posedge clk) begin
    if (accept && !last) begin
      fb_r[pos_cur] <= in_data_byte;
    end
  end

  `GFFC_ASSERT_ALWAYS(a_pos_range, pos_r <= LAST_POS, "byte position out of range")

endmodule

`default_nettype wire

>>> src/gffc_queue.sv
// ----------------------------------------------------------------------------
// gffc_queue
// short frame queue between the byte assembler and the arithmetic pipeline
// ----------------------------------------------------------------------------
`default_nettype none

`include "gyro_fifo_frame_conditioner_unit_defines.svh"

module gffc_queue import gffc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr_en,
  input  wire frame_t wr_data,
  output logic        full,
  input  wire logic   rd_en,
  output frame_t      rd_data,
  output logic        empty
);

  frame_t           mem_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [MQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [MQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == MQ_CW'(MQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == MQ_AW'(MQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == MQ_AW'(MQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `GFFC_ASSERT_ALWAYS(a_mq_bound, cnt_r <= MQ_CW'(MQ_DEPTH), "frame queue count overflow")

endmodule

`default_nettype wire

>>> src/gffc_back.sv
// ----------------------------------------------------------------------------
// gffc_back
// bias, scale, round, axis remap, saturation and the result queue
// ----------------------------------------------------------------------------
`default_nettype none

`include "gyro_fifo_frame_conditioner_unit_defines.svh"

module gffc_back import gffc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire frame_t q_frame,
  input  wire logic   q_empty,
  output logic        q_pop,
  input  wire logic   pop,
  output logic        empty,
  output result_t     res
);

  // pipeline registers
  logic               s1_v_r;
  frame_t             s1_frame_r;
  logic signed [20:0] s1_corr_r [3];
  logic               s2_v_r;
  frame_t             s2_frame_r;
  logic signed [41:0] s2_prod_r [3];

  logic signed [20:0] corr_nxt  [3];
  logic signed [41:0] prod_nxt  [3];
  logic signed [29:0] rate_a    [3];
  count_t             raw_a     [3];
  logic signed [19:0] bias_a    [3];
  rate_t              out_rate  [3];
  logic [2:0]         clip_a;
  result_t            res_nxt;

  // result queue
  result_t          oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_r, oq_rd_r;
  logic [OQ_CW-1:0] oq_cnt_r, oq_cnt_nxt;
  logic [OQ_CW-1:0] committed;
  logic             oq_wr, oq_rd;

  // take a frame only when its result already has a slot reserved
  assign committed = oq_cnt_r + OQ_CW'(s1_v_r) + OQ_CW'(s2_v_r);
  assign q_pop     = !q_empty && (committed < OQ_CW'(OQ_DEPTH));

  // stage 1: align count to q.4 and remove bias
  always_comb begin
    raw_a[0]  = q_frame.raw_x;
    raw_a[1]  = q_frame.raw_y;
    raw_a[2]  = q_frame.raw_z;
    bias_a[0] = cfg.bias_x;
    bias_a[1] = cfg.bias_y;
    bias_a[2] = cfg.bias_z;
    for (int i = 0; i < 3; i++) begin
      corr_nxt[i] = $signed({raw_a[i][15], raw_a[i], 4'b0000})
                  - $signed({bias_a[i][19], bias_a[i]});
    end
  end

  // stage 2: one multiply per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = s1_corr_r[i] * $signed({1'b0, cfg.rate_scale});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_frame_r <= q_frame;
    s2_frame_r <= s1_frame_r;
    for (int i = 0; i < 3; i++) begin
      s1_corr_r[i] <= corr_nxt[i];
      s2_prod_r[i] <= prod_nxt[i];
    end
  end

  // stage 3: round half up to q.16, remap, negate, saturate
  always_comb begin
    logic signed [41:0] sum;
    logic signed [29:0] src;
    logic signed [30:0] v;
    logic [1:0]         sel;
    for (int i = 0; i < 3; i++) begin
      sum       = s2_prod_r[i] + 42'sd2048;
      rate_a[i] = sum[41:12];
    end
    for (int k = 0; k < 3; k++) begin
      sel = cfg.axis_map[2*k +: 2];
      case (sel)
        SEL_X:   src = rate_a[0];
        SEL_Y:   src = rate_a[1];
        default: src = rate_a[2];
      endcase
      v = {src[29], src};
      if (cfg.sign_mask[k]) begin
        v = -v;
      end
      clip_a[k] = 1'b0;
      if (v > RATE_MAX) begin
        v         = RATE_MAX;
        clip_a[k] = 1'b1;
      end else if (v < RATE_MIN) begin
        v         = RATE_MIN;
        clip_a[k] = 1'b1;
      end
      out_rate[k] = v[23:0];
    end
    res_nxt.roll_rate  = out_rate[0];
    res_nxt.pitch_rate = out_rate[1];
    res_nxt.yaw_rate   = out_rate[2];
    res_nxt.raw_x      = s2_frame_r.raw_x;
    res_nxt.raw_y      = s2_frame_r.raw_y;
    res_nxt.raw_z      = s2_frame_r.raw_z;
    res_nxt.clipped    = |clip_a;
  end

  // result queue control
  assign oq_wr = s2_v_r;
  assign empty = (oq_cnt_r == '0);
  assign oq_rd = pop && !empty;
  assign res   = oq_r[oq_rd_r];

  always_comb begin
    case ({oq_wr, oq_rd})
      2'b10:   oq_cnt_nxt = oq_cnt_r + 1'b1;
      2'b01:   oq_cnt_nxt = oq_cnt_r - 1'b1;
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_wr) begin
        oq_wr_r <= (oq_wr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wr_r + 1'b1;
      end
      if (oq_rd) begin
        oq_rd_r <= (oq_rd_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_r[oq_wr_r] <= res_nxt;
    end
  end

  `GFFC_ASSERT_ALWAYS(a_credit_bound, committed <= OQ_CW'(OQ_DEPTH), "result slots overbooked")
  `GFFC_ASSERT_NEXT(a_pop_enters, q_pop, s1_v_r, "popped frame did not enter pipeline")

endmodule

`default_nettype wire

>>> src/gyro_fifo_frame_conditioner_unit.sv
// ----------------------------------------------------------------------------
// gyro_fifo_frame_conditioner_unit
// assembles gyro fifo bytes into frames and returns calibrated body rates
// ----------------------------------------------------------------------------
//  channel   ports                           transfer when
//  input     push/full, in_*                 push && !full
//  result    empty/pop, out_*                pop && !empty
//  config    psel/penable/pwrite/paddr/...   psel && penable && pwrite
//
//  one byte is taken every cycle while full is low; frames pass the
//  frame queue and the bias, multiply and round/saturate stages; full
//  rises only while the two-entry frame queue is full, which happens
//  when the four-entry result queue is held up by a stalled reader
//  reset is synchronous; no clearing pass, the block is ready right away
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_fifo_frame_conditioner_unit import gffc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // byte input
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_frame_start,
  // result output
  output logic                   empty,
  input  wire logic              pop,
  output logic signed [23:0]     out_roll_rate,
  output logic signed [23:0]     out_pitch_rate,
  output logic signed [23:0]     out_yaw_rate,
  output logic signed [15:0]     out_raw_x,
  output logic signed [15:0]     out_raw_y,
  output logic signed [15:0]     out_raw_z,
  output logic                   out_clipped,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t    cfg;
  frame_t  fr_wr, fr_rd;
  logic    fq_push, fq_full, fq_pop, fq_empty;
  result_t res;

  // register file
  gffc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte assembler
  gffc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .q_full         (fq_full),
    .q_push         (fq_push),
    .q_frame        (fr_wr)
  );

  // frame queue
  gffc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fr_wr),
    .full    (fq_full),
    .rd_en   (fq_pop),
    .rd_data (fr_rd),
    .empty   (fq_empty)
  );

  // arithmetic pipeline and result queue
  gffc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_frame (fr_rd),
    .q_empty (fq_empty),
    .q_pop   (fq_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_roll_rate  = res.roll_rate;
  assign out_pitch_rate = res.pitch_rate;
  assign out_yaw_rate   = res.yaw_rate;
  assign out_raw_x      = res.raw_x;
  assign out_raw_y      = res.raw_y;
  assign out_raw_z      = res.raw_z;
  assign out_clipped    = res.clipped;

endmodule

`default_nettype wire
